>>> design/lcd_pkg.sv
// ----------------------------------------------------------------------------
// lcd_pkg
// Shared types and constants for the LRU cache tag directory.
// ----------------------------------------------------------------------------
package lcd_pkg;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned OUT_IDX_W = 4;

  typedef enum logic {
    KIND_LOOKUP = 1'b0,
    KIND_FILL   = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic [OUT_IDX_W-1:0] line_index;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic update;
  } cmd_t;

endpackage

>>> design/lcd_ctrl.sv
// ----------------------------------------------------------------------------
// lcd_ctrl
// Controller: sequences each item through capture and directory update.
// ----------------------------------------------------------------------------
module lcd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_valid,
  output lcd_pkg::cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_UPD
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.load      = start && !busy_r;
    cmd.update    = (state_r == S_UPD);
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_UPD;
          busy_nxt  = 1'b1;
        end
      end
      S_UPD: begin
        // The result register is loaded at the end of this cycle.
        state_nxt     = S_IDLE;
        busy_nxt      = 1'b0;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

>>> design/lcd_datapath.sv
// ----------------------------------------------------------------------------
// lcd_datapath
// Tag store, valid bits, recency list, parallel compare and promotion logic.
// ----------------------------------------------------------------------------
module lcd_datapath #(
  parameter int unsigned LINES    = 16,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  lcd_pkg::cmd_t cmd,
  input  lcd_pkg::in_t  in_data,
  output lcd_pkg::out_t out_data
);

  localparam int unsigned IDX_W = $clog2(LINES);

  logic [KEY_BITS-1:0] key_mem_r [LINES];
  logic [LINES-1:0]    valid_r;
  logic [IDX_W-1:0]    order_r [LINES];
  logic [IDX_W-1:0]    order_nxt [LINES];

  lcd_pkg::kind_t      kind_r;
  logic [KEY_BITS-1:0] key_r;
  logic [LINES-1:0]    match_r, match_nxt;
  lcd_pkg::out_t       out_r, out_nxt;

  logic [IDX_W-1:0]           hit_idx;
  logic                       any_hit;
  logic                       is_fill;
  logic                       do_promote;
  logic [IDX_W-1:0]           line_sel;
  logic [LINES-1:0]           pos_hit;
  logic [LINES-1:0]           shift;
  logic [IDX_W+lcd_pkg::OUT_IDX_W-1:0] line_ext;

  // Compare the incoming key against every valid line while the store is stable.
  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      match_nxt[i] = valid_r[i] && (key_mem_r[i] == in_data.key[KEY_BITS-1:0]);
    end
  end

  // Lowest matching line wins.
  always_comb begin
    hit_idx = '0;
    for (int i = LINES - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign any_hit    = |match_r;
  assign is_fill    = (kind_r == lcd_pkg::KIND_FILL);
  assign do_promote = is_fill || any_hit;
  assign line_sel   = is_fill ? order_r[LINES-1] : hit_idx;

  // Positions at or above the promoted line shift down by one.
  always_comb begin
    for (int p = 0; p < LINES; p++) begin
      pos_hit[p] = (order_r[p] == line_sel);
    end
    for (int p = 0; p < LINES; p++) begin
      shift[p] = ((pos_hit >> p) != '0);
    end
    order_nxt[0] = line_sel;
    for (int p = 1; p < LINES; p++) begin
      order_nxt[p] = shift[p] ? order_r[p-1] : order_r[p];
    end
  end

  assign line_ext = {{lcd_pkg::OUT_IDX_W{1'b0}}, line_sel};

  always_comb begin
    out_nxt.hit        = !is_fill && any_hit;
    out_nxt.line_index = do_promote ? line_ext[lcd_pkg::OUT_IDX_W-1:0]
                                    : '0;
  end

  // Item capture and result payload carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_data.kind;
      key_r   <= in_data.key[KEY_BITS-1:0];
      match_r <= match_nxt;
    end
    if (cmd.update) begin
      out_r <= out_nxt;
      if (is_fill) begin
        key_mem_r[line_sel] <= key_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < LINES; i++) begin
        order_r[i] <= IDX_W'(i);
      end
    end else if (cmd.update) begin
      if (is_fill) begin
        valid_r[line_sel] <= 1'b1;
      end
      if (do_promote) begin
        order_r <= order_nxt;
      end
    end
  end

  assign out_data = out_r;

endmodule

>>> design/lru_cache_tag_directory.sv
// ----------------------------------------------------------------------------
// lru_cache_tag_directory
// Fully associative tag directory with true LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   An item (lookup or fill plus a key) is accepted at a clock edge where
//   start is high and busy is low. A lookup compares the low KEY_BITS of the
//   key against all valid lines; a hit promotes that line to most recently
//   used. A fill writes the key into the least recently used line, marks it
//   valid and promotes it.
//   The key compare runs at the accept edge. The next edge updates the
//   recency list and tag store and loads the result, so out_data is shown
//   with out_valid high for exactly one cycle.
//   busy is high for one cycle after each accept, so a new item cannot be
//   taken while the previous one updates the recency list and tag store.
//   Reset (synchronous, rst_n low) clears all valid bits and sets the
//   recency list to line 0 most recent down to line LINES-1 least recent.
//   Results cannot be stalled: out_valid is a single-cycle strobe.
// ----------------------------------------------------------------------------
module lru_cache_tag_directory #(
  parameter int unsigned LINES    = 16,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  lcd_pkg::in_t  in_data,
  output logic          out_valid,
  output lcd_pkg::out_t out_data
);

  lcd_pkg::cmd_t cmd;

  lcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  lcd_datapath #(
    .LINES    (LINES),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

  // Every accepted item is followed by the update state and then its result.
  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted item did not enter the update cycle");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy))
    else $error("result strobe without a preceding update cycle");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (!busy && out_valid))
    else $error("update cycle did not produce exactly one result");

endmodule
